// ===== rtl/core/sps_pkg.sv =====
`timescale 1ns / 1ps

package sps_pkg;

    localparam int SINE_ENTRIES = 32;
    localparam int TABLE_SCALE  = 32768;
    localparam int IDX_W        = $clog2(SINE_ENTRIES);
    localparam int MICRO_W      = IDX_W + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [15:0] t_level;

    localparam logic [1:0] MODE_FULL = 2'd0;
    localparam logic [1:0] MODE_HALF = 2'd1;

    localparam logic [1:0] ACT_STEP = 2'd0;
    localparam logic [1:0] ACT_STOP = 2'd1;
    localparam logic [1:0] ACT_LOAD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_AMP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_AMP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE    = 3'd5;

    localparam t_level AMP_LIMIT = 16'd32768;

    // quarter-sine entry, rescaled to the table scale
    function automatic t_level sine_value(input logic [IDX_W-1:0] idx);
        logic [15:0] raw;
        logic [31:0] scaled;
        unique case (idx)
            5'd0:  raw = 16'd804;
            5'd1:  raw = 16'd2411;
            5'd2:  raw = 16'd4011;
            5'd3:  raw = 16'd5602;
            5'd4:  raw = 16'd7180;
            5'd5:  raw = 16'd8740;
            5'd6:  raw = 16'd10279;
            5'd7:  raw = 16'd11793;
            5'd8:  raw = 16'd13279;
            5'd9:  raw = 16'd14733;
            5'd10: raw = 16'd16151;
            5'd11: raw = 16'd17531;
            5'd12: raw = 16'd18868;
            5'd13: raw = 16'd20160;
            5'd14: raw = 16'd21403;
            5'd15: raw = 16'd22595;
            5'd16: raw = 16'd23732;
            5'd17: raw = 16'd24812;
            5'd18: raw = 16'd25833;
            5'd19: raw = 16'd26791;
            5'd20: raw = 16'd27684;
            5'd21: raw = 16'd28511;
            5'd22: raw = 16'd29269;
            5'd23: raw = 16'd29957;
            5'd24: raw = 16'd30572;
            5'd25: raw = 16'd31114;
            5'd26: raw = 16'd31581;
            5'd27: raw = 16'd31972;
            5'd28: raw = 16'd32286;
            5'd29: raw = 16'd32522;
            5'd30: raw = 16'd32679;
            default: raw = 16'd32758;
        endcase
        scaled = 32'(raw) * 32'(TABLE_SCALE) + 32'd16384;
        return scaled[30:15];
    endfunction

    function automatic t_level clamp_amp(input t_level v);
        return (v > AMP_LIMIT) ? AMP_LIMIT : v;
    endfunction

endpackage

// ===== rtl/core/stepper_phase_sequencer.sv =====
`timescale 1ns / 1ps
// order: an item passes the input stage, then the result register
// throughput: one item per cycle when not stalled, set by the single
//   compute stage that updates phase, position and coil state together
// reset: synchronous active-low; config returns to defaults; phases,
//   position, coils, amplitude clear to zero; input data not reset
module stepper_phase_sequencer #(
    parameter int POSITION_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_action,
    input  logic                           i_reverse,
    input  logic signed [31:0]             i_preset_position,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [15:0]                    o_coil_a,
    output logic [15:0]                    o_coil_b,
    output logic [15:0]                    o_coil_c,
    output logic [15:0]                    o_coil_d,
    output logic [15:0]                    o_scale_amplitude,
    output logic signed [31:0]             o_current_position
);
    import sps_pkg::*;

    // config
    logic [1:0] r_step_mode;
    t_level     r_full_level;
    t_level     r_half_level;
    t_level     r_run_amp;
    t_level     r_hold_amp;
    logic       r_release;

    // input stage
    logic        r_in_vld;
    logic [1:0]  r_action;
    logic        r_reverse;
    logic [31:0] r_preset;

    // state, doubles as the result register
    logic                     r_out_vld;
    logic [2:0]               r_coarse, n_coarse;
    logic [MICRO_W-1:0]       r_micro, n_micro;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    t_level                   r_coils [4];
    t_level                   n_coils [4];
    t_level                   r_amp, n_amp;

    logic             w_adv;
    logic [IDX_W-1:0] w_idx;
    t_level           w_s;
    t_level           w_c;
    t_level           w_f;
    t_level           w_h;
    logic [63:0]      w_preset_ext;
    logic [63:0]      w_pos_ext;

    assign w_adv      = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_mode  <= 2'd2;
            r_full_level <= 16'd32768;
            r_half_level <= 16'd23170;
            r_run_amp    <= 16'd32768;
            r_hold_amp   <= 16'd8192;
            r_release    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STEP_MODE:  r_step_mode  <= i_cfg_data[1:0];
                REG_FULL_LEVEL: r_full_level <= i_cfg_data;
                REG_HALF_LEVEL: r_half_level <= i_cfg_data;
                REG_RUN_AMP:    r_run_amp    <= i_cfg_data;
                REG_HOLD_AMP:   r_hold_amp   <= i_cfg_data;
                REG_RELEASE:    r_release    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action  <= i_action;
            r_reverse <= i_reverse;
            r_preset  <= i_preset_position;
        end
    end

    assign w_idx        = r_micro[IDX_W-1:0];
    assign w_s          = sine_value(w_idx);
    assign w_c          = sine_value(~w_idx);
    assign w_f          = r_full_level;
    assign w_h          = r_half_level;
    assign w_preset_ext = {{32{r_preset[31]}}, r_preset};

    always_comb begin
        n_coarse = r_coarse;
        n_micro  = r_micro;
        n_pos    = r_pos;
        n_amp    = r_amp;
        for (int k = 0; k < 4; k++) begin
            n_coils[k] = r_coils[k];
        end
        unique case (r_action)
            ACT_STEP: begin
                n_amp = clamp_amp(r_run_amp);
                n_pos = r_reverse ? r_pos - 1'b1 : r_pos + 1'b1;
                if (r_step_mode == MODE_FULL) begin
                    n_coarse = r_reverse ? r_coarse + 3'd2 : r_coarse + 3'd6;
                    unique case (r_coarse)
                        3'd0: n_coils = '{16'd0, w_f, 16'd0, w_f};
                        3'd2: n_coils = '{16'd0, w_f, w_f, 16'd0};
                        3'd4: n_coils = '{w_f, 16'd0, w_f, 16'd0};
                        3'd6: n_coils = '{w_f, 16'd0, 16'd0, w_f};
                        default: begin
                            n_coils  = '{16'd0, 16'd0, 16'd0, 16'd0};
                            n_coarse = 3'd0;
                        end
                    endcase
                end else if (r_step_mode == MODE_HALF) begin
                    n_coarse = r_reverse ? r_coarse + 3'd1 : r_coarse + 3'd7;
                    unique case (r_coarse)
                        3'd0:    n_coils = '{16'd0, w_f, 16'd0, 16'd0};
                        3'd1:    n_coils = '{16'd0, w_h, w_h, 16'd0};
                        3'd2:    n_coils = '{16'd0, 16'd0, w_f, 16'd0};
                        3'd3:    n_coils = '{w_h, 16'd0, w_h, 16'd0};
                        3'd4:    n_coils = '{w_f, 16'd0, 16'd0, 16'd0};
                        3'd5:    n_coils = '{w_h, 16'd0, 16'd0, w_h};
                        3'd6:    n_coils = '{16'd0, 16'd0, 16'd0, w_f};
                        default: n_coils = '{16'd0, w_h, 16'd0, w_h};
                    endcase
                end else begin
                    n_micro = r_micro + 1'b1;
                    unique case ({r_reverse, r_micro[MICRO_W-1 -: 2]})
                        3'b000:  n_coils = '{16'd0, w_c, 16'd0, w_s};
                        3'b001:  n_coils = '{w_s, 16'd0, 16'd0, w_c};
                        3'b010:  n_coils = '{w_c, 16'd0, w_s, 16'd0};
                        3'b011:  n_coils = '{16'd0, w_s, w_c, 16'd0};
                        3'b100:  n_coils = '{16'd0, w_c, w_s, 16'd0};
                        3'b101:  n_coils = '{w_s, 16'd0, w_c, 16'd0};
                        3'b110:  n_coils = '{w_c, 16'd0, 16'd0, w_s};
                        default: n_coils = '{16'd0, w_s, 16'd0, w_c};
                    endcase
                end
            end
            ACT_STOP: begin
                n_amp = clamp_amp(r_hold_amp);
                if (r_release) begin
                    n_coils = '{16'd0, 16'd0, 16'd0, 16'd0};
                end
            end
            ACT_LOAD: begin
                n_pos = w_preset_ext[POSITION_BITS-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_coarse  <= '0;
            r_micro   <= '0;
            r_pos     <= '0;
            r_amp     <= '0;
            for (int k = 0; k < 4; k++) begin
                r_coils[k] <= '0;
            end
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_coarse <= n_coarse;
                r_micro  <= n_micro;
                r_pos    <= n_pos;
                r_amp    <= n_amp;
                for (int k = 0; k < 4; k++) begin
                    r_coils[k] <= n_coils[k];
                end
            end
        end
    end

    assign w_pos_ext          = 64'(r_pos);
    assign o_out_valid        = r_out_vld;
    assign o_coil_a           = r_coils[0];
    assign o_coil_b           = r_coils[1];
    assign o_coil_c           = r_coils[2];
    assign o_coil_d           = r_coils[3];
    assign o_scale_amplitude  = r_amp;
    assign o_current_position = w_pos_ext[31:0];

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import sps_pkg::*;

    localparam logic [1:0] MODE_SINE  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [1:0] ACT_NONE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int PHASES       = 18;
    localparam int PHASE_ITEMS  = 25;
    localparam int LONG_HOLD    = 80;
    localparam int MAX_PRINTS   = 50;

    localparam logic [15:0] QUARTER_SINE [0:SINE_ENTRIES-1] = '{
        16'd804,   16'd2411,  16'd4011,  16'd5602,  16'd7180,  16'd8740,  16'd10279, 16'd11793,
        16'd13279, 16'd14733, 16'd16151, 16'd17531, 16'd18868, 16'd20160, 16'd21403, 16'd22595,
        16'd23732, 16'd24812, 16'd25833, 16'd26791, 16'd27684, 16'd28511, 16'd29269, 16'd29957,
        16'd30572, 16'd31114, 16'd31581, 16'd31972, 16'd32286, 16'd32522, 16'd32679, 16'd32758
    };

    typedef struct packed {
        logic [15:0] coil_a;
        logic [15:0] coil_b;
        logic [15:0] coil_c;
        logic [15:0] coil_d;
        logic [15:0] amplitude;
        logic [31:0] position;
    } t_coil_set;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [1:0]            act;
        logic                  rev;
        logic [31:0]           preset;
        logic                  typed;
        t_coil_set             want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic [1:0] i_action;
    logic i_reverse;
    logic signed [31:0] i_preset_position;
    logic o_out_valid;
    logic i_out_ready;
    logic [15:0] o_coil_a;
    logic [15:0] o_coil_b;
    logic [15:0] o_coil_c;
    logic [15:0] o_coil_d;
    logic [15:0] o_scale_amplitude;
    logic signed [31:0] o_current_position;

    // typed expectation travels with the item it belongs to
    logic      item_typed;
    t_coil_set item_want;

    bit quiet = 1'b0;
    bit sender_gaps = 1'b1;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned mismatches = 0;

    t_coil_set pending_drive[$];

    // shadow of the sequencer registers and state
    logic [1:0]         m_mode;
    logic [15:0]        m_full;
    logic [15:0]        m_half;
    logic [15:0]        m_run;
    logic [15:0]        m_hold;
    logic               m_release;
    logic [2:0]         m_coarse;
    logic [MICRO_W-1:0] m_micro;
    logic [31:0]        m_pos;
    logic [3:0][15:0]   m_coils;
    logic [15:0]        m_amp;

    stepper_phase_sequencer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_reverse          (i_reverse),
        .i_preset_position  (i_preset_position),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_coil_a           (o_coil_a),
        .o_coil_b           (o_coil_b),
        .o_coil_c           (o_coil_c),
        .o_coil_d           (o_coil_d),
        .o_scale_amplitude  (o_scale_amplitude),
        .o_current_position (o_current_position)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [15:0] scaled_sine(input logic [IDX_W-1:0] idx);
        logic [31:0] scaled;
        scaled = 32'(QUARTER_SINE[idx]) * 32'(TABLE_SCALE) + 32'd16384;
        return scaled[30:15];
    endfunction

    function automatic t_coil_set next_drive(input logic [1:0] act, input logic rev,
                                             input logic [31:0] preset);
        logic [15:0] f;
        logic [15:0] h;
        logic [15:0] s;
        logic [15:0] c;
        logic [1:0] quad;
        logic [IDX_W-1:0] idx;
        f = m_full;
        h = m_half;
        case (act)
            ACT_STEP: begin
                m_amp = (m_run > AMP_LIMIT) ? AMP_LIMIT : m_run;
                case (m_mode)
                    MODE_FULL: begin
                        case (m_coarse)
                            3'd0: m_coils = {16'd0, f, 16'd0, f};
                            3'd2: m_coils = {16'd0, f, f, 16'd0};
                            3'd4: m_coils = {f, 16'd0, f, 16'd0};
                            3'd6: m_coils = {f, 16'd0, 16'd0, f};
                            default: m_coils = '0;
                        endcase
                        if (m_coarse[0]) begin
                            m_coarse = 3'd0;
                        end else begin
                            m_coarse = rev ? m_coarse + 3'd2 : m_coarse + 3'd6;
                        end
                    end
                    MODE_HALF: begin
                        case (m_coarse)
                            3'd0: m_coils = {16'd0, f, 16'd0, 16'd0};
                            3'd1: m_coils = {16'd0, h, h, 16'd0};
                            3'd2: m_coils = {16'd0, 16'd0, f, 16'd0};
                            3'd3: m_coils = {h, 16'd0, h, 16'd0};
                            3'd4: m_coils = {f, 16'd0, 16'd0, 16'd0};
                            3'd5: m_coils = {h, 16'd0, 16'd0, h};
                            3'd6: m_coils = {16'd0, 16'd0, 16'd0, f};
                            default: m_coils = {16'd0, h, 16'd0, h};
                        endcase
                        m_coarse = rev ? m_coarse + 3'd1 : m_coarse + 3'd7;
                    end
                    default: begin
                        quad = m_micro[MICRO_W-1 -: 2];
                        idx  = m_micro[IDX_W-1:0];
                        s = scaled_sine(idx);
                        c = scaled_sine(~idx);
                        case ({rev, quad})
                            3'b000: m_coils = {16'd0, c, 16'd0, s};
                            3'b001: m_coils = {s, 16'd0, 16'd0, c};
                            3'b010: m_coils = {c, 16'd0, s, 16'd0};
                            3'b011: m_coils = {16'd0, s, c, 16'd0};
                            3'b100: m_coils = {16'd0, c, s, 16'd0};
                            3'b101: m_coils = {s, 16'd0, c, 16'd0};
                            3'b110: m_coils = {c, 16'd0, 16'd0, s};
                            default: m_coils = {16'd0, s, 16'd0, c};
                        endcase
                        m_micro = m_micro + 1'b1;
                    end
                endcase
                m_pos = rev ? m_pos - 32'd1 : m_pos + 32'd1;
            end
            ACT_STOP: begin
                m_amp = (m_hold > AMP_LIMIT) ? AMP_LIMIT : m_hold;
                if (m_release) begin
                    m_coils = '0;
                end
            end
            ACT_LOAD: m_pos = preset;
            default: ;
        endcase
        return {m_coils[3], m_coils[2], m_coils[1], m_coils[0], m_amp, m_pos};
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_row item_row(input logic [1:0] act, input logic rev,
                                      input logic [31:0] preset);
        t_row r;
        r = '0;
        r.act = act;
        r.rev = rev;
        r.preset = preset;
        return r;
    endfunction

    function automatic t_row checked_row(input logic [1:0] act, input logic rev,
                                         input logic [31:0] preset,
                                         input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c, input logic [15:0] d,
                                         input logic [15:0] amp, input logic [31:0] pos);
        t_row r;
        r = item_row(act, rev, preset);
        r.typed = 1'b1;
        r.want = {a, b, c, d, amp, pos};
        return r;
    endfunction

    function automatic logic [15:0] random_level();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return AMP_LIMIT;
            3: return AMP_LIMIT + 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic note_mismatch(input string what);
        if (mismatches < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_STEP_MODE:  m_mode = data[1:0];
            REG_FULL_LEVEL: m_full = data;
            REG_HALF_LEVEL: m_half = data;
            REG_RUN_AMP:    m_run = data;
            REG_HOLD_AMP:   m_hold = data;
            REG_RELEASE:    m_release = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic offer_item(input t_row r);
        if (sender_gaps && !quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_action          <= r.act;
        i_reverse         <= r.rev;
        i_preset_position <= r.preset;
        item_typed        <= r.typed;
        item_want         <= r.want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // result side: random stalls, plus one long hold on request
    initial begin : sink
        int unsigned gap;
        forever begin
            if (hold_seen != hold_req) begin
                hold_seen = hold_seen + 1;
                i_out_ready <= 1'b0;
                gap = LONG_HOLD;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                gap = $urandom_range(1, 12);
            end else begin
                i_out_ready <= 1'b1;
                gap = $urandom_range(1, 6);
            end
            repeat (gap) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_coil_set got;
        t_coil_set want;
        t_coil_set pred;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = {o_coil_a, o_coil_b, o_coil_c, o_coil_d, o_scale_amplitude,
                       o_current_position};
                if (pending_drive.size() == 0) begin
                    note_mismatch($sformatf("result with nothing expected: %h", got));
                end else begin
                    want = pending_drive.pop_front();
                    if (got.coil_a !== want.coil_a)
                        note_mismatch($sformatf("coil_a %0d, expected %0d",
                                                got.coil_a, want.coil_a));
                    if (got.coil_b !== want.coil_b)
                        note_mismatch($sformatf("coil_b %0d, expected %0d",
                                                got.coil_b, want.coil_b));
                    if (got.coil_c !== want.coil_c)
                        note_mismatch($sformatf("coil_c %0d, expected %0d",
                                                got.coil_c, want.coil_c));
                    if (got.coil_d !== want.coil_d)
                        note_mismatch($sformatf("coil_d %0d, expected %0d",
                                                got.coil_d, want.coil_d));
                    if (got.amplitude !== want.amplitude)
                        note_mismatch($sformatf("scale_amplitude %0d, expected %0d",
                                                got.amplitude, want.amplitude));
                    if (got.position !== want.position)
                        note_mismatch($sformatf("current_position %h, expected %h",
                                                got.position, want.position));
                end
            end
            if (i_in_valid && o_in_ready) begin
                pred = next_drive(i_action, i_reverse, i_preset_position);
                pending_drive.push_back(item_typed ? item_want : pred);
            end
        end
    end

    initial begin : stimulus
        t_row plan[$];
        logic [1:0] act;
        logic dir;
        int unsigned pick;
        logic [15:0] word;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = REG_STEP_MODE;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_action          = ACT_STEP;
        i_reverse         = 1'b0;
        i_preset_position = '0;
        item_typed        = 1'b0;
        item_want         = '0;

        m_mode    = MODE_SINE;
        m_full    = 16'd32768;
        m_half    = 16'd23170;
        m_run     = 16'd32768;
        m_hold    = 16'd8192;
        m_release = 1'b0;
        m_coarse  = '0;
        m_micro   = '0;
        m_pos     = '0;
        m_coils   = '0;
        m_amp     = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, sine microstep, position wrap both ways
        plan.push_back(checked_row(ACT_LOAD, 1'b0, 32'h7FFF_FFFF,
                                   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'h7FFF_FFFF));
        plan.push_back(checked_row(ACT_STEP, 1'b0, 32'h0,
                                   16'd0, 16'd32758, 16'd0, 16'd804, 16'd32768, 32'h8000_0000));
        plan.push_back(checked_row(ACT_STEP, 1'b1, 32'h0,
                                   16'd0, 16'd32679, 16'd2411, 16'd0, 16'd32768, 32'h7FFF_FFFF));
        plan.push_back(checked_row(ACT_STOP, 1'b0, 32'hFFFF_FFFF,
                                   16'd0, 16'd32679, 16'd2411, 16'd0, 16'd8192, 32'h7FFF_FFFF));
        plan.push_back(checked_row(ACT_NONE, 1'b1, 32'hFFFF_FFFF,
                                   16'd0, 16'd32679, 16'd2411, 16'd0, 16'd8192, 32'h7FFF_FFFF));
        plan.push_back(checked_row(ACT_LOAD, 1'b1, 32'h8000_0000,
                                   16'd0, 16'd32679, 16'd2411, 16'd0, 16'd8192, 32'h8000_0000));
        plan.push_back(checked_row(ACT_LOAD, 1'b0, 32'hFFFF_FFFF,
                                   16'd0, 16'd32679, 16'd2411, 16'd0, 16'd8192, 32'hFFFF_FFFF));
        plan.push_back(item_row(ACT_STEP, 1'b0, 32'h0));
        plan.push_back(item_row(ACT_STEP, 1'b1, 32'h0));
        // releasing stop
        plan.push_back(cfg_row(REG_RELEASE, 16'h0001));
        plan.push_back(checked_row(ACT_STOP, 1'b0, 32'h0,
                                   16'd0, 16'd0, 16'd0, 16'd0, 16'd8192, 32'hFFFF_FFFF));
        // full step, top level, run amplitude clamp
        plan.push_back(cfg_row(REG_STEP_MODE, {14'd0, MODE_FULL}));
        plan.push_back(cfg_row(REG_FULL_LEVEL, 16'hFFFF));
        plan.push_back(cfg_row(REG_RUN_AMP, 16'hFFFF));
        plan.push_back(checked_row(ACT_STEP, 1'b0, 32'h0,
                                   16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd32768, 32'h0));
        plan.push_back(item_row(ACT_STEP, 1'b0, 32'h0));
        plan.push_back(item_row(ACT_STEP, 1'b1, 32'h0));
        // half step leaves an odd phase, hold amplitude clamp
        plan.push_back(cfg_row(REG_STEP_MODE, {14'd0, MODE_HALF}));
        plan.push_back(cfg_row(REG_FULL_LEVEL, 16'h0000));
        plan.push_back(cfg_row(REG_HALF_LEVEL, 16'hFFFF));
        plan.push_back(cfg_row(REG_HOLD_AMP, 16'hFFFF));
        plan.push_back(item_row(ACT_STEP, 1'b1, 32'h0));
        plan.push_back(item_row(ACT_STEP, 1'b1, 32'h0));
        plan.push_back(item_row(ACT_STEP, 1'b0, 32'h0));
        plan.push_back(item_row(ACT_STOP, 1'b0, 32'h0));
        // full step from an odd phase
        plan.push_back(cfg_row(REG_STEP_MODE, {14'd0, MODE_FULL}));
        plan.push_back(item_row(ACT_STEP, 1'b0, 32'h0));
        plan.push_back(item_row(ACT_STEP, 1'b0, 32'h0));
        // unused mode with upper bits set, zero run amplitude, unused register
        plan.push_back(cfg_row(REG_STEP_MODE, {14'h3FFF, MODE_SPARE}));
        plan.push_back(cfg_row(REG_RUN_AMP, 16'h0000));
        plan.push_back(cfg_row(REG_RELEASE, 16'hFFFE));
        plan.push_back(cfg_row(REG_SPARE, 16'hFFFF));
        plan.push_back(item_row(ACT_STEP, 1'b0, 32'h0));
        plan.push_back(item_row(ACT_STEP, 1'b1, 32'h0));
        plan.push_back(item_row(ACT_STOP, 1'b1, 32'h0));
        plan.push_back(item_row(ACT_LOAD, 1'b0, 32'h0));

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                offer_item(plan[k]);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 4) begin
                quiet <= 1'b1;
            end
            word = 16'($urandom);
            word[1:0] = 2'($urandom_range(0, 3));
            write_reg(REG_STEP_MODE, word);
            write_reg(REG_FULL_LEVEL, random_level());
            write_reg(REG_HALF_LEVEL, random_level());
            write_reg(REG_RUN_AMP, random_level());
            write_reg(REG_HOLD_AMP, random_level());
            write_reg(REG_RELEASE, 16'($urandom));
            if (p == 4) begin
                // outputs held back while items keep coming
                hold_req <= hold_req + 1;
                sender_gaps = 1'b0;
            end
            dir = 1'($urandom_range(0, 1));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 8 && k == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                if ($urandom_range(0, 4) == 0) begin
                    dir = ~dir;
                end
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    act = ACT_STEP;
                end else if (pick < 16) begin
                    act = ACT_STOP;
                end else if (pick < 18) begin
                    act = ACT_LOAD;
                end else begin
                    act = ACT_NONE;
                end
                offer_item(item_row(act, dir, $urandom));
            end
            sender_gaps = 1'b1;
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
